[design/stil_pkg.sv]
// Shared constants, codes and types for the sorted table index lookup.
package stil_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 12;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ORDER    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Position reported when nothing matches
  localparam logic signed [POS_W-1:0] POS_NONE = '1;

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic signed [POS_W-1:0]     pos_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

endpackage

[design/stil_if.sv]
// Request and response channel interfaces for the sorted table index lookup.
interface stil_req_if;
  logic                                valid;
  logic                                ready;
  logic [stil_pkg::MODE_W-1:0]         mode;
  logic signed [stil_pkg::KEY_WIDTH-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface stil_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [stil_pkg::STATUS_W-1:0]       status;
  logic signed [stil_pkg::POS_W-1:0]   position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

[design/stil_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module stil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sorted_table_index_lookup.sv]
// Top level: sorted key table with binary-search lookup.
//
// Usage: items arrive on the req channel (mode, key) and each gives exactly
// one item on the rsp channel (status, position); both use valid/ready.
// A load appends the key when the table has room and the key is not below
// the last stored key, a clear empties the table, a query searches it.
// Load, clear and unused-mode items finish in the accept cycle; the result
// is visible in the next cycle, and with a ready receiver one such item is
// taken every cycle. A query runs a binary search with one table RAM read
// per cycle, and the next item can be accepted at the edge that takes its
// result. The RAM's registered read sets the pace: each probe address is
// issued in the cycle before its compare, the first in the accept cycle,
// and the last compare loads the output register. Queries on an empty
// table answer at once.
// The block takes one item at a time: req.ready is high only when no search
// is running and the output register is empty or being taken. A stalled
// receiver holds the result and blocks new items. Reset (rst, synchronous)
// empties the table and drops any pending result; no clearing pass is run.
module sorted_table_index_lookup (
  input  logic              clk,
  input  logic              rst,
  stil_req_if.sink          req,
  stil_rsp_if.source        rsp
);

  stil_pkg::state_t state, state_next;

  // Table bookkeeping
  stil_pkg::cnt_t count;
  stil_pkg::key_t last_key;

  // Search registers
  stil_pkg::key_t qkey;
  stil_pkg::cnt_t lo, hi, mid;
  logic           hit;

  // Output register
  logic                            out_valid;
  logic [stil_pkg::STATUS_W-1:0]   out_status;
  stil_pkg::pos_t                  out_position;

  // RAM port signals
  logic                              ram_we;
  logic [stil_pkg::ADDR_W-1:0]       ram_waddr;
  logic [stil_pkg::ADDR_W-1:0]       ram_raddr;
  logic [stil_pkg::KEY_WIDTH-1:0]    ram_rdata;

  logic acc;
  logic out_free;
  logic is_full;
  logic is_order;
  logic load_ok;

  // One search step
  logic           less;
  stil_pkg::cnt_t lo_s, hi_s, mid_s;
  logic           hit_s;
  logic           done_s;

  stil_ram #(
    .WIDTH (stil_pkg::KEY_WIDTH),
    .DEPTH (stil_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.key),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || rsp.ready;
  assign acc      = req.valid && req.ready;

  // Load checks: fullness first, then order
  assign is_full  = (count == stil_pkg::CNT_W'(stil_pkg::TABLE_DEPTH));
  assign is_order = (count != '0) && (req.key < last_key);
  assign load_ok  = !is_full && !is_order;

  // Compare the probed entry and narrow the window
  always_comb begin
    less   = $signed(ram_rdata) < qkey;
    lo_s   = less ? mid + stil_pkg::CNT_W'(1) : lo;
    hi_s   = less ? hi : mid;
    hit_s  = less ? hit : ($signed(ram_rdata) == qkey);
    mid_s  = lo_s + ((hi_s - lo_s) >> 1);
    done_s = !(lo_s < hi_s);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      stil_pkg::S_IDLE: begin
        if (acc && req.mode == stil_pkg::MODE_QUERY && count != '0) begin
          state_next = stil_pkg::S_SEARCH;
        end
      end
      stil_pkg::S_SEARCH: begin
        if (done_s) begin
          state_next = stil_pkg::S_IDLE;
        end
      end
      default: state_next = stil_pkg::S_IDLE;
    endcase
  end

  // Handshake and RAM controls
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count[stil_pkg::ADDR_W-1:0];
    ram_raddr = mid_s[stil_pkg::ADDR_W-1:0];
    case (state)
      stil_pkg::S_IDLE: begin
        req.ready = out_free;
        ram_we    = acc && req.mode == stil_pkg::MODE_LOAD && load_ok;
        ram_raddr = count[stil_pkg::CNT_W-1:1];
      end
      stil_pkg::S_SEARCH: begin
        ram_raddr = mid_s[stil_pkg::ADDR_W-1:0];
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stil_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (acc) begin
        case (req.mode)
          stil_pkg::MODE_LOAD: begin
            out_valid <= 1'b1;
            if (load_ok) begin
              count <= count + stil_pkg::CNT_W'(1);
            end
          end
          stil_pkg::MODE_QUERY: begin
            if (count == '0) begin
              out_valid <= 1'b1;
            end
          end
          stil_pkg::MODE_CLEAR: begin
            out_valid <= 1'b1;
            count     <= '0;
          end
          default: begin
            out_valid <= 1'b1;
          end
        endcase
      end else if (state == stil_pkg::S_SEARCH && done_s) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      out_position <= stil_pkg::POS_NONE;
      out_status   <= stil_pkg::ST_OK;
      case (req.mode)
        stil_pkg::MODE_LOAD: begin
          if (is_full) begin
            out_status <= stil_pkg::ST_FULL;
          end else if (is_order) begin
            out_status <= stil_pkg::ST_ORDER;
          end else begin
            last_key <= req.key;
          end
        end
        stil_pkg::MODE_QUERY: begin
          qkey <= req.key;
          lo   <= '0;
          hi   <= count;
          mid  <= count >> 1;
          hit  <= 1'b0;
          out_status <= stil_pkg::ST_NOTFOUND;
        end
        default: begin
          out_status <= stil_pkg::ST_OK;
        end
      endcase
    end else if (state == stil_pkg::S_SEARCH) begin
      lo  <= lo_s;
      hi  <= hi_s;
      mid <= mid_s;
      hit <= hit_s;
      if (done_s) begin
        if (hit_s) begin
          out_status   <= stil_pkg::ST_OK;
          out_position <= stil_pkg::POS_W'(lo_s) + stil_pkg::POS_W'(1);
        end else begin
          out_status   <= stil_pkg::ST_NOTFOUND;
          out_position <= stil_pkg::POS_NONE;
        end
      end
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_position;

`ifndef SYNTH
  // Entry count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= stil_pkg::CNT_W'(stil_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Search window stays open while searching
  a_window: assert property (@(posedge clk) disable iff (rst)
    state == stil_pkg::S_SEARCH |-> (lo < hi) && (mid >= lo) && (mid < hi))
    else $error("search window invalid");

  // No result is pending while a search runs
  a_search_out: assert property (@(posedge clk) disable iff (rst)
    state == stil_pkg::S_SEARCH |-> !out_valid)
    else $error("result pending during search");

  // A load either grows the table by one or reports a reject
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    acc && req.mode == stil_pkg::MODE_LOAD |=>
      (count == $past(count) + stil_pkg::CNT_W'(1)) ||
      (count == $past(count) && rsp.status != stil_pkg::ST_OK))
    else $error("load count update mismatch");
`endif

endmodule

[test/stil_lookup_checker.sv]
// Checker for the sorted table index lookup: predicts each result and compares it.
`timescale 1ns / 1ps

module stil_lookup_checker
  import stil_pkg::*;
(
  input  logic clk,
  input  logic rst,
  stil_req_if  req,
  stil_rsp_if  rsp,
  output int   mismatch_count,
  output int   pending_results,
  output int   results_checked
);

  // One awaited result, with the item that caused it for messages
  typedef struct {
    logic [MODE_W-1:0]   mode;
    key_t                key;
    logic [STATUS_W-1:0] status;
    pos_t                position;
  } lookup_result_t;

  // Shadow copy of the table
  key_t           stored_keys [TABLE_DEPTH];
  cnt_t           stored_count;
  lookup_result_t awaited_q [$];

  // Update the shadow table for one item and return the result it must give
  function automatic lookup_result_t apply_item(logic [MODE_W-1:0] m, key_t k);
    lookup_result_t r;
    int             lo;
    int             hi;
    int             mid;
    r.mode     = m;
    r.key      = k;
    r.status   = ST_OK;
    r.position = POS_NONE;
    case (m)
      MODE_LOAD: begin
        // fullness is checked before order; equal keys are accepted
        if (stored_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (stored_count != 0 &&
                     k < stored_keys[ADDR_W'(stored_count - 1'b1)]) begin
          r.status = ST_ORDER;
        end else begin
          stored_keys[stored_count[ADDR_W-1:0]] = k;
          stored_count = stored_count + 1'b1;
        end
      end
      MODE_QUERY: begin
        // lower bound gives the lowest of several equal keys
        lo = 0;
        hi = int'(stored_count);
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (stored_keys[ADDR_W'(mid)] < k) lo = mid + 1;
          else hi = mid;
        end
        if (lo < int'(stored_count) && stored_keys[ADDR_W'(lo)] == k) begin
          r.position = pos_t'(lo + 1);
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      MODE_CLEAR: begin
        stored_count = '0;
      end
      default: begin
        // unused mode: no effect on the table
      end
    endcase
    return r;
  endfunction

  function automatic void note_mismatch(string what, int want_v, int got_v,
                                        lookup_result_t item);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s mismatch for mode %0d key %0d: expected %0d, got %0d",
               $time, what, item.mode, item.key, want_v, got_v);
    end
  endfunction

  // Results are compared before new items are predicted in the same cycle
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      stored_count = '0;
      awaited_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result (status %0d, position %0d), none pending",
                     $time, rsp.status, rsp.position);
          end
        end else begin
          want = awaited_q.pop_front();
          results_checked++;
          if (rsp.status !== want.status) begin
            note_mismatch("status", want.status, rsp.status, want);
          end
          if (rsp.position !== want.position) begin
            note_mismatch("position", want.position, rsp.position, want);
          end
        end
      end
      if (req.valid && req.ready) begin
        awaited_q.push_back(apply_item(req.mode, req.key));
      end
    end
    pending_results <= awaited_q.size();
  end

endmodule

[test/sorted_table_index_lookup_tb.sv]
// Testbench top for the sorted table index lookup: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module sorted_table_index_lookup_tb;
  import stil_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam longint KEY_HI = 64'sd2147483647;
  localparam longint KEY_LO = -KEY_HI - 1;

  localparam int ITEM_TARGET    = 1800;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 20;

  logic clk;
  logic rst;

  stil_req_if req_if ();
  stil_rsp_if rsp_if ();

  int mismatch_count;
  int pending_results;
  int results_checked;

  // Stimulus bookkeeping
  key_t loaded_keys [$];
  int   burst_left;
  int   items_sent;
  int   n_load, n_query, n_clear, n_unused;
  int   peak_fill;
  int   holds_asked;
  int   holds_done;
  int   idle_cycles;

  sorted_table_index_lookup i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  stil_lookup_checker i_lookup_chk (
    .clk             (clk),
    .rst             (rst),
    .req             (req_if),
    .rsp             (rsp_if),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one item, in bursts with random gaps, and wait until it is taken
  task automatic send_item(input logic [MODE_W-1:0] m, input key_t k);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(50, 150);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 10);
      end
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.mode  <= m;
    req_if.key   <= k;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load(input key_t k);
    send_item(MODE_LOAD, k);
    n_load++;
    if (loaded_keys.size() < TABLE_DEPTH &&
        (loaded_keys.size() == 0 || k >= loaded_keys[$])) begin
      loaded_keys.push_back(k);
    end
    if (loaded_keys.size() > peak_fill) peak_fill = loaded_keys.size();
  endtask

  task automatic query(input key_t k);
    send_item(MODE_QUERY, k);
    n_query++;
  endtask

  task automatic clear_table();
    send_item(MODE_CLEAR, key_t'($urandom));
    n_clear++;
    loaded_keys.delete();
  endtask

  task automatic ignore_item(input key_t k);
    send_item(MODE_UNUSED, k);
    n_unused++;
  endtask

  // Query mostly stored keys, some neighbors, some random keys
  task automatic query_pick();
    int   r;
    key_t k;
    r = $urandom_range(0, 9);
    if (loaded_keys.size() != 0 && r < 7) begin
      k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
      if (r == 5) k = k + 1;
      else if (r == 6) k = k - 1;
    end else begin
      k = key_t'($urandom);
    end
    query(k);
  endtask

  // Ascending load run with queries mixed in; noisy runs add bad and odd items
  task automatic run_session(input int n_keys, input int other_pct, input bit noisy);
    longint cur;
    longint stepcap;
    longint next_key;
    int     placed;
    int     r;
    placed = 0;
    if (!noisy || loaded_keys.size() == 0 || $urandom_range(0, 4) != 0) begin
      clear_table();
    end
    if (!noisy) cur = KEY_LO;
    else if (loaded_keys.size() != 0) cur = longint'(loaded_keys[$]);
    else cur = longint'($signed($urandom));
    stepcap = (KEY_HI - cur) / (n_keys + 1);
    while (placed < n_keys) begin
      r = $urandom_range(0, 99);
      if (r >= other_pct) begin
        r = $urandom_range(0, 9);
        if (r < 2) next_key = cur;
        else if (r < 4) next_key = cur + $urandom_range(1, 3);
        else next_key = cur + longint'($urandom) % (stepcap + 1);
        if (next_key > KEY_HI) next_key = KEY_HI;
        cur = next_key;
        load(key_t'(cur));
        placed++;
      end else begin
        r = $urandom_range(0, 9);
        if (!noisy || r < 6) begin
          query_pick();
        end else if (r == 6) begin
          // key below the last stored one
          if (loaded_keys.size() != 0 && longint'(loaded_keys[$]) != KEY_LO) begin
            next_key = longint'(loaded_keys[$]) - 1 - $urandom_range(0, 1000);
            if (next_key < KEY_LO) next_key = KEY_LO;
            load(key_t'(next_key));
          end else begin
            load(key_t'($urandom));
          end
        end else if (r == 7) begin
          ignore_item(key_t'($urandom));
        end else if (r == 8) begin
          load(key_t'($urandom));
        end else begin
          query(key_t'($urandom));
        end
      end
    end
    repeat ($urandom_range(2, 6)) query_pick();
  endtask

  // Main stimulus and verdict
  initial begin
    int waited;
    rst           = 1'b1;
    req_if.valid  = 1'b0;
    req_if.mode   = MODE_LOAD;
    req_if.key    = '0;
    burst_left    = 0;
    holds_asked   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, unused mode, extreme keys, duplicates, order errors
    query(key_t'(0));
    ignore_item(key_t'(32'h5A5A_A5A5));
    load(key_t'(KEY_LO));
    holds_asked <= holds_asked + 1;
    load(key_t'(KEY_LO));
    load(key_t'(-5));
    load(key_t'(-6));
    load(key_t'(0));
    load(key_t'(7));
    load(key_t'(KEY_HI));
    load(key_t'(100));
    query(key_t'(KEY_LO));
    query(key_t'(KEY_HI));
    query(key_t'(7));
    query(key_t'(3));
    query(key_t'(-5));
    query(key_t'(-1));
    clear_table();
    query(key_t'(7));

    // Fill the table to the top, then loads into a full table
    run_session(TABLE_DEPTH, 8, 1'b0);
    holds_asked <= holds_asked + 1;
    load(key_t'(KEY_HI));
    load(key_t'(KEY_LO));
    query(loaded_keys[$]);
    query(loaded_keys[0]);
    repeat (6) query_pick();

    // Small random tables
    while (items_sent < ITEM_TARGET) begin
      run_session($urandom_range(1, 40), 45, 1'b1);
    end

    // Drain
    req_if.valid <= 1'b0;
    waited = 0;
    while (pending_results != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d loads, %0d queries, %0d clears, %0d unused mode.",
             items_sent, n_load, n_query, n_clear, n_unused);
    $display("Compared %0d results; table held up to %0d keys; %0d long receiver stalls.",
             results_checked, peak_fill, holds_done);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: ready pattern that changes style every so often, plus long hold-offs
  initial begin
    int style;
    int phase_left;
    int tick;
    rsp_if.ready = 1'b0;
    holds_done   = 0;
    style        = 0;
    phase_left   = 0;
    tick         = 0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      if (phase_left == 0) begin
        style      = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 200);
      end
      phase_left--;
      tick++;
      case (style)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
        2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_if.ready <= ((tick % 8) < 5);
      endcase
    end
  end

  // Watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
